[design/epr_pkg.sv]
// ----------------------------------------------------------------------------
// epr_pkg
// Shared types, codes and the sequencer microcode for the empirical p-value
// ranker.
// ----------------------------------------------------------------------------
package epr_pkg;

	localparam int FUNC_W  = 2;
	localparam int SCORE_W = 32;
	localparam int P_W     = 17;
	localparam int STAT_W  = 2;
	localparam int SCNT_W  = 11;
	localparam int QBITS   = 17;   // quotient bits of the p-value division
	localparam int DCNT_W  = 5;

	localparam logic [P_W-1:0] ONE_Q16 = 17'h10000;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic signed [SCORE_W-1:0] score;
	} in_word_t;

	typedef struct packed {
		logic [P_W-1:0]    p_value;
		logic [STAT_W-1:0] status;
		logic [SCNT_W-1:0] stored_count;
	} out_word_t;

	typedef logic [3:0] step_t;

	localparam step_t S_WAIT     = 4'd0;
	localparam step_t S_DISPATCH = 4'd1;
	localparam step_t S_QCHK     = 4'd2;
	localparam step_t S_SCAN     = 4'd3;
	localparam step_t S_DIVINIT  = 4'd4;
	localparam step_t S_DIV      = 4'd5;
	localparam step_t S_QFIN     = 4'd6;
	localparam step_t S_SIMPLE   = 4'd7;
	localparam step_t S_EMPTY    = 4'd8;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_SCAN_INIT,
		OP_SCAN,
		OP_DIV_INIT,
		OP_DIV,
		OP_FIN_QUERY,
		OP_FIN_SIMPLE,
		OP_FIN_EMPTY
	} op_t;

	typedef enum logic [2:0] {
		C_NO_ITEM,
		C_NOT_QUERY,
		C_EMPTY,
		C_SCAN_MORE,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	// one control word: datapath op, jump condition, taken / not-taken step
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jmp;
		step_t nxt;
	} ctrl_t;

	typedef struct packed {
		logic no_item;
		logic not_query;
		logic empty;
		logic scan_more;
		logic div_more;
		logic out_busy;
	} flags_t;

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '{op: OP_NOP, cond: C_NO_ITEM, jmp: S_WAIT, nxt: S_WAIT};
		case (s)
			S_WAIT:     w = '{op: OP_ACCEPT,     cond: C_NO_ITEM,   jmp: S_WAIT,   nxt: S_DISPATCH};
			S_DISPATCH: w = '{op: OP_NOP,        cond: C_NOT_QUERY, jmp: S_SIMPLE, nxt: S_QCHK};
			S_QCHK:     w = '{op: OP_SCAN_INIT,  cond: C_EMPTY,     jmp: S_EMPTY,  nxt: S_SCAN};
			S_SCAN:     w = '{op: OP_SCAN,       cond: C_SCAN_MORE, jmp: S_SCAN,   nxt: S_DIVINIT};
			S_DIVINIT:  w = '{op: OP_DIV_INIT,   cond: C_OUT_BUSY,  jmp: S_DIV,    nxt: S_DIV};
			S_DIV:      w = '{op: OP_DIV,        cond: C_DIV_MORE,  jmp: S_DIV,    nxt: S_QFIN};
			S_QFIN:     w = '{op: OP_FIN_QUERY,  cond: C_OUT_BUSY,  jmp: S_QFIN,   nxt: S_WAIT};
			S_SIMPLE:   w = '{op: OP_FIN_SIMPLE, cond: C_OUT_BUSY,  jmp: S_SIMPLE, nxt: S_WAIT};
			S_EMPTY:    w = '{op: OP_FIN_EMPTY,  cond: C_OUT_BUSY,  jmp: S_EMPTY,  nxt: S_WAIT};
			default:    w = '{op: OP_NOP,        cond: C_NO_ITEM,   jmp: S_WAIT,   nxt: S_WAIT};
		endcase
		return w;
	endfunction

endpackage

[design/epr_seq.sv]
// ----------------------------------------------------------------------------
// epr_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module epr_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  epr_pkg::flags_t flags,
	output epr_pkg::ctrl_t  ctrl
);
	import epr_pkg::*;

	step_t upc_q;
	logic  take;

	assign ctrl = ucode(upc_q);

	always_comb begin
		case (ctrl.cond)
			C_NO_ITEM:   take = flags.no_item;
			C_NOT_QUERY: take = flags.not_query;
			C_EMPTY:     take = flags.empty;
			C_SCAN_MORE: take = flags.scan_more;
			C_DIV_MORE:  take = flags.div_more;
			C_OUT_BUSY:  take = flags.out_busy;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_WAIT;
		end else begin
			upc_q <= take ? ctrl.jmp : ctrl.nxt;
		end
	end

endmodule

[design/empirical_pvalue_ranker.sv]
// ----------------------------------------------------------------------------
// empirical_pvalue_ranker
// Mid-rank empirical p-value of a query score against a store of background
// scores, clamped to [p_floor, 1.0]; microcoded control over a plain datapath.
// ----------------------------------------------------------------------------
//  channel  | signals                          | word
//  ---------+----------------------------------+------------------------------
//  in       | in_valid / in_ready / in_data    | func, score
//  out      | out_valid / out_ready / out_data | p_value, status, stored_count
//  cfg      | cfg_we / cfg_wdata               | p_floor (write only)
//
//  Clear, load and unused func codes go straight to the final step; a query
//  on N stored scores makes one store read per cycle, then a 17-step
//  restoring division by 2N; an empty store skips both. One item at a time.
//  No reset-time sweep: the store is only compared below the fill count.
//  A finished word waits in the output register while the next word is taken;
//  the sequencer holds in its final step while that register is still full.
// ----------------------------------------------------------------------------
module empirical_pvalue_ranker #(
	parameter int NEG_DEPTH  = 1024,
	parameter int SCORE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  epr_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output epr_pkg::out_word_t out_data,
	input  logic               cfg_we,
	input  logic [16:0]        cfg_wdata
);
	import epr_pkg::*;

	localparam int AW    = $clog2(NEG_DEPTH);
	localparam int CNT_W = $clog2(NEG_DEPTH + 1);
	localparam int MW    = CNT_W + 1;

	ctrl_t  ctrl;
	flags_t flags;

	in_word_t  item_q;
	out_word_t out_q;
	logic      out_valid_q;
	logic [P_W-1:0]   p_floor_q;
	logic [CNT_W-1:0] count_q;

	logic signed [SCORE_BITS-1:0] mem [NEG_DEPTH];
	logic signed [SCORE_BITS-1:0] rd_q;
	logic [AW-1:0]                rd_addr;
	logic                         mem_we;
	logic signed [SCORE_BITS-1:0] score_ext;

	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  low_q;
	logic [CNT_W-1:0]  up_q;
	logic [MW:0]       r_q;
	logic [QBITS-1:0]  q_q;
	logic [DCNT_W-1:0] div_cnt_q;

	logic              go;
	logic              full;
	logic [MW-1:0]     m_val;
	logic [MW-1:0]     c_sum;
	logic              ge;
	logic [MW-1:0]     rem;
	logic [P_W-1:0]    p_lo;
	logic [P_W-1:0]    p_clamp;
	logic [CNT_W-1:0]  new_count;
	logic [STAT_W-1:0] simple_status;
	logic [SCNT_W-1:0] cnt_rep;

	epr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	if (SCORE_BITS <= SCORE_W) begin : g_score_narrow
		assign score_ext = item_q.score[SCORE_BITS-1:0];
	end else begin : g_score_wide
		assign score_ext = {{(SCORE_BITS-SCORE_W){item_q.score[SCORE_W-1]}}, item_q.score};
	end

	if (CNT_W >= SCNT_W) begin : g_cnt_trunc
		assign cnt_rep = new_count[SCNT_W-1:0];
	end else begin : g_cnt_ext
		assign cnt_rep = {{(SCNT_W-CNT_W){1'b0}}, new_count};
	end

	assign in_ready  = (ctrl.op == OP_ACCEPT);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign go        = !out_valid_q || out_ready;
	assign full      = (count_q == CNT_W'(NEG_DEPTH));

	assign flags.no_item   = !in_valid;
	assign flags.not_query = (item_q.func != FUNC_QUERY);
	assign flags.empty     = (count_q == '0);
	assign flags.scan_more = (idx_q < count_q);
	assign flags.div_more  = (div_cnt_q != '0);
	assign flags.out_busy  = !go;

	// store access
	assign mem_we  = (ctrl.op == OP_FIN_SIMPLE) && go && (item_q.func == FUNC_LOAD) && !full;
	assign rd_addr = (ctrl.op == OP_SCAN) ? idx_q[AW-1:0] : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[AW-1:0]] <= score_ext;
		end
		rd_q <= mem[rd_addr];
	end

	// division and clamp
	assign m_val = {count_q, 1'b0};
	assign c_sum = MW'(low_q) + MW'(up_q);
	assign ge    = (r_q >= {1'b0, m_val});
	assign rem   = ge ? MW'(r_q - {1'b0, m_val}) : r_q[MW-1:0];
	assign p_lo    = (q_q < p_floor_q) ? p_floor_q : q_q;
	assign p_clamp = (p_lo > ONE_Q16) ? ONE_Q16 : p_lo;

	always_comb begin
		new_count     = count_q;
		simple_status = ST_OK;
		case (ctrl.op)
			OP_FIN_SIMPLE: begin
				case (item_q.func)
					FUNC_CLEAR: new_count = '0;
					FUNC_LOAD: begin
						if (full) begin
							simple_status = ST_FULL;
						end else begin
							new_count = count_q + 1'b1;
						end
					end
					default: new_count = count_q;
				endcase
			end
			default: new_count = count_q;
		endcase
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_ACCEPT: begin
				if (in_valid) begin
					item_q <= in_data;
				end
			end
			OP_SCAN_INIT: begin
				idx_q <= CNT_W'(1);
				low_q <= '0;
				up_q  <= '0;
			end
			OP_SCAN: begin
				// compare entry idx-1 while reading entry idx
				low_q <= low_q + CNT_W'(rd_q < score_ext);
				up_q  <= up_q + CNT_W'(rd_q <= score_ext);
				idx_q <= idx_q + 1'b1;
			end
			OP_DIV_INIT: begin
				r_q       <= {1'b0, m_val - c_sum};
				div_cnt_q <= DCNT_W'(QBITS - 1);
			end
			OP_DIV: begin
				r_q       <= {rem, 1'b0};
				q_q       <= {q_q[QBITS-2:0], ge};
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			p_floor_q   <= P_W'(1);
		end else begin
			if (cfg_we) begin
				p_floor_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (go) begin
				case (ctrl.op)
					OP_FIN_QUERY: begin
						out_valid_q        <= 1'b1;
						out_q.p_value      <= p_clamp;
						out_q.status       <= ST_OK;
						out_q.stored_count <= cnt_rep;
					end
					OP_FIN_EMPTY: begin
						out_valid_q        <= 1'b1;
						out_q.p_value      <= ONE_Q16;
						out_q.status       <= ST_EMPTY;
						out_q.stored_count <= cnt_rep;
					end
					OP_FIN_SIMPLE: begin
						out_valid_q        <= 1'b1;
						out_q.p_value      <= '0;
						out_q.status       <= simple_status;
						out_q.stored_count <= cnt_rep;
						count_q            <= new_count;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

[design/epr_chk.sv]
// ----------------------------------------------------------------------------
// epr_chk
// Port-level checks for the empirical p-value ranker, bound to the top level.
// ----------------------------------------------------------------------------
module epr_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input epr_pkg::out_word_t out_data
);
	import epr_pkg::*;

	// a taken word keeps the input closed for at least the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EMPTY |->
			out_data.p_value == ONE_Q16 && out_data.stored_count == '0)
		else $error("empty-store query word malformed");

	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FULL |-> out_data.p_value == '0)
		else $error("dropped load carries a p-value");

	a_p_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.p_value <= ONE_Q16)
		else $error("p-value above 1.0");

endmodule

bind empirical_pvalue_ranker epr_chk u_epr_chk (.*);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for empirical_pvalue_ranker. A directed table covers the
// empty store, the unused func code, score extremes, ties and the p_floor
// clamp. Random phases follow, each under its own p_floor setting: clear, load
// and query runs, noise and broken runs. Words with no tabled result are checked
// against an in-bench mid-rank scorer. The sender idles in bursts and the receiver
// stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import epr_pkg::*;

	localparam int NEG_DEPTH   = 1024;
	localparam int SCORE_BITS  = 32;
	localparam int DIR_ROWS    = 21;
	localparam int PHASE_ITEMS = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 1000000;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	localparam logic [P_W-1:0] FLOOR_SET [7] = '{
		17'd0, 17'h1ffff, 17'd65536, 17'd65535, 17'd65537, 17'd0, 17'd1
	};

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [SCORE_W-1:0] score;
		logic               known;
		out_word_t          want;
	} row_t;

	// known rows carry their word; the rest go through the scorer
	row_t dir_tab [DIR_ROWS] = '{
		'{FUNC_QUERY,  32'h0000_0000, 1'b1, '{ONE_Q16, ST_EMPTY, 11'd0}},
		'{FUNC_UNUSED, 32'hffff_ffff, 1'b1, '{17'd0, ST_OK, 11'd0}},
		'{FUNC_CLEAR,  32'h0000_0000, 1'b1, '{17'd0, ST_OK, 11'd0}},
		'{FUNC_LOAD,   32'h8000_0000, 1'b1, '{17'd0, ST_OK, 11'd1}},
		'{FUNC_LOAD,   32'h7fff_ffff, 1'b1, '{17'd0, ST_OK, 11'd2}},
		'{FUNC_LOAD,   32'h0000_0000, 1'b1, '{17'd0, ST_OK, 11'd3}},
		'{FUNC_LOAD,   32'h0000_0000, 1'b1, '{17'd0, ST_OK, 11'd4}},
		'{FUNC_QUERY,  32'h8000_0000, 1'b0, '0},
		'{FUNC_QUERY,  32'h7fff_ffff, 1'b0, '0},
		'{FUNC_QUERY,  32'h0000_0000, 1'b0, '0},
		'{FUNC_QUERY,  32'hffff_ffff, 1'b0, '0},
		'{FUNC_QUERY,  32'h0000_0001, 1'b0, '0},
		'{FUNC_UNUSED, 32'h5555_5555, 1'b1, '{17'd0, ST_OK, 11'd4}},
		'{FUNC_LOAD,   32'hffff_ffff, 1'b1, '{17'd0, ST_OK, 11'd5}},
		'{FUNC_QUERY,  32'haaaa_aaaa, 1'b0, '0},
		'{FUNC_CLEAR,  32'h7fff_ffff, 1'b1, '{17'd0, ST_OK, 11'd0}},
		'{FUNC_QUERY,  32'h1234_5678, 1'b1, '{ONE_Q16, ST_EMPTY, 11'd0}},
		'{FUNC_LOAD,   32'h0005_0000, 1'b1, '{17'd0, ST_OK, 11'd1}},
		'{FUNC_QUERY,  32'h0005_0000, 1'b0, '0},
		'{FUNC_QUERY,  32'h0005_0001, 1'b0, '0},
		'{FUNC_QUERY,  32'h0004_ffff, 1'b0, '0}
	};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;
	logic      cfg_we    = 1'b0;
	logic [16:0] cfg_wdata = '0;

	// scorer state
	logic signed [SCORE_W-1:0] neg_scores [NEG_DEPTH];
	int unsigned               neg_n     = 0;
	logic [P_W-1:0]            floor_q16 = 17'd1;

	out_word_t pending_words [$];
	int        errors      = 0;
	int        counted     = 0;
	int        burst_left  = 0;
	bit        hold_req    = 1'b0;
	int unsigned cycles    = 0;

	empirical_pvalue_ranker #(
		.NEG_DEPTH (NEG_DEPTH),
		.SCORE_BITS(SCORE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial forever #10 clk = ~clk;

	// mid-rank p-value of one word; advances the store as the block would
	function automatic out_word_t rank_word(input in_word_t w);
		out_word_t r;
		logic signed [SCORE_W-1:0] s;
		int unsigned lo, hi, i;
		longint m, p;
		r = '0;
		s = w.score;
		case (w.func)
			FUNC_CLEAR: neg_n = 0;
			FUNC_LOAD: begin
				if (neg_n >= NEG_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					neg_scores[neg_n] = s;
					neg_n++;
				end
			end
			FUNC_QUERY: begin
				if (neg_n == 0) begin
					r.p_value = ONE_Q16;
					r.status  = ST_EMPTY;
				end else begin
					lo = 0;
					hi = 0;
					for (i = 0; i < neg_n; i++) begin
						if (neg_scores[i] < s) lo++;
						if (neg_scores[i] <= s) hi++;
					end
					m = 2 * longint'(neg_n);
					p = ((m - lo - hi) * 65536) / m;
					if (p < longint'(floor_q16)) p = floor_q16;
					if (p > 65536) p = 65536;
					r.p_value = p[P_W-1:0];
				end
			end
			default: ;
		endcase
		r.stored_count = neg_n[SCNT_W-1:0];
		return r;
	endfunction

	// mix of wide random, small ties, extremes, near-copies of stored scores and 17-bit signed values
	function automatic logic [SCORE_W-1:0] pick_score();
		logic [SCORE_W-1:0] v;
		int unsigned k;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: v = 32'($urandom_range(0, 16)) - 32'd8;
			2: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'h0000_0000;
					default: v = 32'hffff_ffff;
				endcase
			end
			3: begin
				if (neg_n == 0) begin
					v = $urandom;
				end else begin
					k = $urandom_range(0, neg_n - 1);
					v = neg_scores[k] + 32'($urandom_range(0, 2)) - 32'd1;
				end
			end
			default: v = {{16{1'($urandom_range(0, 1))}}, 16'($urandom)};
		endcase
		return v;
	endfunction

	// sender idles between bursts of random length
	task automatic pace();
		int g;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic put_word(input in_word_t w, input logic known, input out_word_t typed);
		out_word_t r;
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		r = rank_word(w);
		pending_words = {pending_words, (known ? typed : r)};
		pace();
	endtask

	task automatic offer(input logic [FUNC_W-1:0] f, input logic [SCORE_W-1:0] s);
		put_word(in_word_t'{f, s}, 1'b0, '0);
		if (f != FUNC_UNUSED) counted++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_floor(input logic [P_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		floor_q16 = v;
	endtask

	task automatic run_random(input int target);
		int start, kind, n;
		start = counted;
		while (counted - start < target) begin
			// keep query scans short
			if (neg_n > 200) offer(FUNC_CLEAR, pick_score());
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				offer(FUNC_CLEAR, pick_score());
				n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32);
				repeat (n) offer(FUNC_LOAD, pick_score());
				repeat ($urandom_range(1, 6)) offer(FUNC_QUERY, pick_score());
			end else if (kind == 6) begin
				repeat ($urandom_range(1, 8)) offer(FUNC_LOAD, pick_score());
				repeat ($urandom_range(1, 3)) offer(FUNC_QUERY, pick_score());
			end else if (kind <= 8) begin
				repeat ($urandom_range(1, 6)) offer(2'($urandom_range(0, 3)), $urandom);
			end else begin
				// broken run: query straight after clear, then up to three loads and an unused code before a second query
				offer(FUNC_CLEAR, pick_score());
				offer(FUNC_QUERY, pick_score());
				repeat ($urandom_range(0, 3)) offer(FUNC_LOAD, pick_score());
				offer(FUNC_UNUSED, pick_score());
				offer(FUNC_QUERY, pick_score());
			end
		end
	endtask

	// receiver stall pattern, plus the long hold-off on request
	initial begin
		int seg, kind;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			kind = $urandom_range(0, 3);
			seg  = $urandom_range(5, 60);
			repeat (seg) begin
				case (kind)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				errors++;
				$display("%0t: word with none expected, got p %0d st %0d cnt %0d", $time,
					out_data.p_value, out_data.status, out_data.stored_count);
			end else begin
				want = pending_words.pop_front();
				if (out_data.p_value !== want.p_value) begin
					errors++;
					$display("%0t: p_value expected %0d, got %0d", $time,
						want.p_value, out_data.p_value);
				end
				if (out_data.status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d, got %0d", $time,
						want.status, out_data.status);
				end
				if (out_data.stored_count !== want.stored_count) begin
					errors++;
					$display("%0t: stored_count expected %0d, got %0d", $time,
						want.stored_count, out_data.stored_count);
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int r, ph;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIR_ROWS; r++) begin
			put_word(in_word_t'{dir_tab[r].func, dir_tab[r].score},
				dir_tab[r].known, dir_tab[r].want);
		end

		for (ph = 0; ph < 7; ph++) begin
			set_floor((ph == 5) ? 17'($urandom_range(0, 65536)) : FLOOR_SET[ph]);
			if (ph == 1) hold_req = 1'b1;
			run_random(PHASE_ITEMS);
		end

		drain();
		repeat (40) @(posedge clk);
		if (pending_words.size() != 0) begin
			errors++;
			$display("%0t: %0d words never arrived", $time, pending_words.size());
		end
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
